### hdl/chull_pkg.sv
// Shared types and codes for the monotone chain convex hull core.
`default_nettype none
package chull_pkg;
    localparam int unsigned StatusWidth = 2;
    typedef enum logic [StatusWidth-1:0] {
        ST_OK       = 2'd0,
        ST_FAIL     = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;
    localparam int unsigned MaxResults = 32;
endpackage
`default_nettype wire

### hdl/chull_ram.sv
// Generic single-port-write, one-port-read RAM with registered read data.
`default_nettype none
module chull_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/chull_turn.sv
// Shared turn test unit: sign of (ax-ox)(by-oy) - (ay-oy)(bx-ox), multi-cycle.
`default_nettype none
module chull_turn #(
    parameter int unsigned CW = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [CW-1:0] i_ox,
    input  wire logic signed [CW-1:0] i_oy,
    input  wire logic signed [CW-1:0] i_ax,
    input  wire logic signed [CW-1:0] i_ay,
    input  wire logic signed [CW-1:0] i_bx,
    input  wire logic signed [CW-1:0] i_by,
    output logic                      o_done,
    output logic                      o_ccw
);
    // step 0: differences, step 1: products, step 2: subtract/sign
    logic signed [CW:0]       r_d0, r_d1, r_d2, r_d3;
    logic signed [2*CW+1:0]   r_p0, r_p1;
    logic [2:0]               r_ph;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d0 <= (CW+1)'(i_ax) - (CW+1)'(i_ox);
            r_d1 <= (CW+1)'(i_by) - (CW+1)'(i_oy);
            r_d2 <= (CW+1)'(i_ay) - (CW+1)'(i_oy);
            r_d3 <= (CW+1)'(i_bx) - (CW+1)'(i_ox);
        end
        r_p0 <= r_d0 * r_d1;
        r_p1 <= r_d2 * r_d3;
        o_ccw <= r_p0 > r_p1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0;
        end else begin
            r_ph <= {r_ph[1:0], i_start};
        end
    end
    assign o_done = r_ph[2];
endmodule
`default_nettype wire

### hdl/convex_hull_2d_monotone_chain_core.sv
// Top level of the monotone chain convex hull core.
// Load: each point is inserted into the sorted store, shifting larger entries up by one.
// Hull: every point but the last is fetched twice; each stack test reads two stack
// entries and runs the turn unit. Emit: one stack read per vertex; output register holds.
// Ready is low while busy.
// Reset (synchronous, active low) clears count, stack depth, overflow, output valid and FSM.
`default_nettype none
module convex_hull_2d_monotone_chain_core #(
    parameter int unsigned MAX_POINTS  = 32,
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic                          i_last_point,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0]      o_hull_x,
    output logic signed [COORD_WIDTH-1:0]      o_hull_y,
    output logic [1:0]                         o_status,
    output logic                               o_last_vertex
);
    import chull_pkg::*;

    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned PW  = 2 * CW;
    localparam int unsigned AW  = $clog2(MAX_POINTS);
    localparam int unsigned SD  = MAX_POINTS + 1;
    localparam int unsigned SAW = $clog2(SD);
    localparam int unsigned NW  = $clog2(MAX_POINTS + 2);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_SRD   = 16'h0002, // read store[i-1] for insertion
        S_SCMP  = 16'h0004,
        S_HCHK  = 16'h0008, // decide whether a turn test is needed
        S_HRD0  = 16'h0010, // read stack[d-2]
        S_HRD1  = 16'h0020, // read stack[d-1]
        S_HRDW  = 16'h0040,
        S_HTURN = 16'h0080,
        S_HWAIT = 16'h0100,
        S_PUSH  = 16'h0200,
        S_FETCH = 16'h0400, // read next store point
        S_FWAIT = 16'h0800,
        S_ERD   = 16'h1000,
        S_EWAIT = 16'h2000,
        S_EOUT  = 16'h4000,
        S_FAIL  = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic [NW-1:0]  r_count, n_count;
    logic [NW-1:0]  r_i, n_i;        // insertion index / hull scan index
    logic [NW-1:0]  r_depth, n_depth;
    logic [NW-1:0]  r_lower, n_lower;
    logic           r_upper, n_upper;
    logic           r_ovf, n_ovf;
    logic           r_last, n_last;
    logic [NW-1:0]  r_k, n_k;        // emit index
    logic [PW-1:0]  r_p, n_p;        // current point (x,y)
    logic [PW-1:0]  r_o, n_o;        // stack[d-2]
    logic [PW-1:0]  r_a, n_a;        // stack[d-1]
    logic           r_ov, n_ov;
    logic [PW-1:0]  r_od, n_od;
    logic [1:0]     r_ost, n_ost;
    logic           r_olast, n_olast;

    // store RAM
    logic           s_we;
    logic [AW-1:0]  s_wa, s_ra;
    logic [PW-1:0]  s_wd, s_rd;
    chull_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd)
    );
    // stack RAM
    logic           k_we;
    logic [SAW-1:0] k_wa, k_ra;
    logic [PW-1:0]  k_rd;
    chull_ram #(.WIDTH(PW), .DEPTH(SD)) u_stack (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_wa), .i_wdata(r_p),
        .i_raddr(k_ra), .o_rdata(k_rd)
    );

    logic t_start, t_done, t_ccw;
    chull_turn #(.CW(CW)) u_turn (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(t_start),
        .i_ox(r_o[PW-1:CW]), .i_oy(r_o[CW-1:0]),
        .i_ax(r_a[PW-1:CW]), .i_ay(r_a[CW-1:0]),
        .i_bx(r_p[PW-1:CW]), .i_by(r_p[CW-1:0]),
        .o_done(t_done), .o_ccw(t_ccw)
    );

    logic signed [CW-1:0] px, py, sx, sy;
    logic                 p_less;
    logic [NW-1:0]        emit_n;
    assign px = r_p[PW-1:CW];
    assign py = r_p[CW-1:0];
    assign sx = s_rd[PW-1:CW];
    assign sy = s_rd[CW-1:0];
    assign p_less = (px < sx) || (px == sx && py < sy);
    assign emit_n = (r_depth > NW'(MaxResults)) ? NW'(MaxResults) : r_depth;

    // Output register parts the sides: a waiting result does not block loading.
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_hull_x      = r_od[PW-1:CW];
    assign o_hull_y      = r_od[CW-1:0];
    assign o_status      = r_ost;
    assign o_last_vertex = r_olast;

    always_comb begin
        n_state = r_state; n_count = r_count; n_i = r_i; n_depth = r_depth;
        n_lower = r_lower; n_upper = r_upper; n_ovf = r_ovf; n_last = r_last;
        n_k = r_k; n_p = r_p; n_o = r_o; n_a = r_a;
        n_ov = r_ov; n_od = r_od; n_ost = r_ost; n_olast = r_olast;
        s_we = 1'b0; s_wa = '0; s_wd = r_p; s_ra = '0;
        k_we = 1'b0; k_wa = '0; k_ra = '0; t_start = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_p = {i_point_x, i_point_y};
                    n_last = i_last_point;
                    n_i = r_count;
                    if (r_count < NW'(MAX_POINTS)) begin
                        n_state = S_SRD;
                    end else begin
                        n_ovf = 1'b1;
                        n_state = S_SCMP;
                        n_i = '0;
                    end
                end
            end
            S_SRD: begin
                s_ra = AW'(r_i - 1'b1);
                n_state = S_SCMP;
                if (r_i == '0) n_state = S_SCMP;
            end
            S_SCMP: begin
                // r_i==count means a real insertion in progress when count<max
                if (r_count < NW'(MAX_POINTS) && r_i != '0 && p_less) begin
                    s_we = 1'b1; s_wa = AW'(r_i); s_wd = s_rd;
                    n_i = r_i - 1'b1;
                    n_state = S_SRD;
                end else begin
                    if (r_count < NW'(MAX_POINTS)) begin
                        s_we = 1'b1; s_wa = AW'(r_i); s_wd = r_p;
                        n_count = r_count + 1'b1;
                    end
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if ((r_count < NW'(MAX_POINTS) ? r_count + 1'b1 : r_count)
                                 < NW'(3)) begin
                        n_state = S_FAIL;
                    end else begin
                        n_i = '0; n_depth = '0; n_upper = 1'b0;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                s_ra = AW'(r_i);
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                n_p = s_rd;
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (r_depth >= NW'(2) && (!r_upper || r_depth > r_lower)) begin
                    n_state = S_HRD0;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_HRD0: begin
                k_ra = SAW'(r_depth - NW'(2));
                n_state = S_HRD1;
            end
            S_HRD1: begin
                k_ra = SAW'(r_depth - 1'b1);
                n_o = k_rd;
                n_state = S_HRDW;
            end
            S_HRDW: begin
                n_a = k_rd;
                n_state = S_HTURN;
            end
            S_HTURN: begin
                t_start = 1'b1;
                n_state = S_HWAIT;
            end
            S_HWAIT: begin
                if (t_done) begin
                    if (!t_ccw) begin
                        n_depth = r_depth - 1'b1;
                        n_state = S_HCHK;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (r_depth < NW'(SD)) begin
                    k_we = 1'b1; k_wa = SAW'(r_depth);
                    n_depth = r_depth + 1'b1;
                end
                n_state = S_FETCH;
                if (!r_upper) begin
                    if (r_i == r_count - 1'b1) begin
                        n_upper = 1'b1;
                        n_lower = (r_depth < NW'(SD)) ? r_depth + 1'b1 : r_depth;
                        if (r_count == NW'(1)) n_state = S_ERD;
                        else n_i = r_count - NW'(2);
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else if (r_i == '0) begin
                    n_state = S_ERD;
                    n_depth = ((r_depth < NW'(SD)) ? r_depth + 1'b1 : r_depth) - 1'b1;
                    n_k = '0;
                end else begin
                    n_i = r_i - 1'b1;
                end
            end
            S_ERD: begin
                if (r_depth < NW'(3)) begin
                    n_state = S_FAIL;
                end else begin
                    k_ra = SAW'(r_k);
                    n_state = S_EWAIT;
                end
            end
            S_EWAIT: begin
                // keep the address so the read data stays on stack[k]
                k_ra = SAW'(r_k);
                n_state = S_EOUT;
            end
            S_EOUT: begin
                k_ra = SAW'(r_k);
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_od = k_rd;
                    n_ost = r_ovf ? ST_OVERFLOW : ST_OK;
                    n_olast = (r_k + 1'b1 == emit_n);
                    if (r_k + 1'b1 == emit_n) begin
                        n_state = S_IDLE;
                        n_count = '0; n_depth = '0; n_ovf = 1'b0;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            S_FAIL: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1; n_od = '0; n_ost = ST_FAIL; n_olast = 1'b1;
                    n_state = S_IDLE;
                    n_count = '0; n_depth = '0; n_ovf = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_depth <= '0; r_ovf <= 1'b0;
            r_ov <= 1'b0; r_upper <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_depth <= n_depth;
            r_ovf <= n_ovf; r_ov <= n_ov; r_upper <= n_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_lower <= n_lower; r_last <= n_last; r_k <= n_k;
        r_p <= n_p; r_o <= n_o; r_a <= n_a; r_od <= n_od;
        r_ost <= n_ost; r_olast <= n_olast;
    end

    // Assertions
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_POINTS)) else $error("point count beyond capacity");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_od)))
        else $error("result changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FAIL) |-> o_last_vertex)
        else $error("failure not marked last");
endmodule
`default_nettype wire
